@@ rtl/core/frkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// frkvc_pkg: shared types for the FIFO-replaced key-value cache
// Operation codes, controller states and the command/status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package frkvc_pkg;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_ADD = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction, restart the scan
    logic scan;    // read/compare one entry per cycle
    logic commit;  // write the table and load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;      // compared entry holds the key
    logic miss_done;  // every filled entry compared, no match
    logic op_nop;     // unused operation code
  } status_t;

endpackage

@@ rtl/core/frkvc_dp.sv @@
// ----------------------------------------------------------------------------
// frkvc_dp: key-value cache datapath
// Key/value memories, scan counter, fill count, victim pointer, add and
// the output payload register.
// ----------------------------------------------------------------------------
module frkvc_dp #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_operation,
  input  logic [63:0]           in_key,
  input  logic signed [63:0]    in_value,
  input  frkvc_pkg::cmd_t       cmd,
  output frkvc_pkg::status_t    sts,
  output logic signed [63:0]    out_result_value,
  output logic                  out_hit
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL     = CW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [63:0]         val_mem [ENTRIES];

  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [63:0]         value_r;
  logic [CW-1:0]       cnt_r;
  logic                cmp_vld_r;
  logic [IW-1:0]       cmp_idx_r;
  logic [KEY_BITS-1:0] key_q;
  logic [63:0]         val_q;
  logic                hit_r;
  logic [IW-1:0]       hit_idx_r;
  logic [63:0]         old_r;
  logic [63:0]         sum_r;
  logic [IW-1:0]       vp_r;
  logic [IW-1:0]       vp_nxt;
  logic [CW-1:0]       fill_r;
  logic [63:0]         result_r;
  logic                hit_out_r;

  logic                iss_more;
  logic                rd_en;
  logic                is_set, is_get, is_add;
  logic                wr_val, do_insert;
  logic [IW-1:0]       wr_addr;
  logic [63:0]         wr_data;
  logic [63:0]         res_nxt;

  // entries below the fill count are the valid ones (FIFO fill never leaves holes)
  assign iss_more = cnt_r < fill_r;
  assign rd_en    = cmd.scan && iss_more;

  assign is_set = (op_r == frkvc_pkg::OP_SET);
  assign is_get = (op_r == frkvc_pkg::OP_GET);
  assign is_add = (op_r == frkvc_pkg::OP_ADD);

  assign sts.match     = cmp_vld_r && (key_q == key_r);
  assign sts.miss_done = !iss_more && !sts.match;
  assign sts.op_nop    = !(is_set || is_get || is_add);

  assign wr_val    = is_set || is_add;
  assign do_insert = wr_val && !hit_r;
  assign wr_addr   = hit_r ? hit_idx_r : vp_r;
  assign wr_data   = (is_add && hit_r) ? sum_r : value_r;
  assign vp_nxt    = (vp_r == LAST_IDX) ? '0 : vp_r + IW'(1);

  always_comb begin
    res_nxt = '0;
    if (is_add) begin
      res_nxt = hit_r ? sum_r : value_r;
    end else if (is_get && hit_r) begin
      res_nxt = old_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      vp_r      <= '0;
      fill_r    <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r     <= '0;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= iss_more;
        if (iss_more) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (sts.match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit && do_insert) begin
        vp_r <= vp_nxt;
        if (fill_r != FULL) begin
          fill_r <= fill_r + CW'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      key_r   <= in_key[KEY_BITS-1:0];
      value_r <= in_value;
    end
    if (cmd.scan) begin
      cmp_idx_r <= cnt_r[IW-1:0];
      if (sts.match) begin
        hit_idx_r <= cmp_idx_r;
        old_r     <= val_q;
        sum_r     <= val_q + value_r;
      end
    end
    if (cmd.commit) begin
      result_r  <= res_nxt;
      hit_out_r <= hit_r;
    end
  end

  // table memories: one read port, one write port each
  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_q <= key_mem[cnt_r[IW-1:0]];
      val_q <= val_mem[cnt_r[IW-1:0]];
    end
    if (cmd.commit && wr_val) begin
      val_mem[wr_addr] <= wr_data;
    end
    if (cmd.commit && do_insert) begin
      key_mem[vp_r] <= key_r;
    end
  end

  assign out_result_value = result_r;
  assign out_hit          = hit_out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond table size");

  a_vp_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FULL) |-> (CW'(vp_r) == fill_r))
    else $error("victim pointer out of step with fill count");

  a_match_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.match) |-> (CW'(cmp_idx_r) < fill_r))
    else $error("match on an unfilled entry");

endmodule

@@ rtl/core/frkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// frkvc_ctrl: key-value cache controller
// Input handshake, scan/update sequencing and output valid.
// ----------------------------------------------------------------------------
module frkvc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  frkvc_pkg::status_t   sts,
  output frkvc_pkg::cmd_t      cmd
);

  frkvc_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frkvc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      frkvc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = frkvc_pkg::S_SCAN;
        end
      end
      frkvc_pkg::S_SCAN: begin
        cmd.scan = !sts.op_nop;
        if (sts.op_nop || sts.match || sts.miss_done) begin
          state_nxt = frkvc_pkg::S_UPD;
        end
      end
      frkvc_pkg::S_UPD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = frkvc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = frkvc_pkg::S_IDLE;
      end
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid = out_valid_r;

  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result raised without a commit");

endmodule

@@ rtl/core/fifo_replaced_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// fifo_replaced_key_value_cache: key-value table with FIFO replacement
// Set / get / add on a signed 64-bit value per key; misses on set and add
// insert a new entry, overwriting the oldest inserted entry once the table is full.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------
//  input    | in_operation, in_key, in_value          | in_valid / in_stall
//  result   | out_result_value, out_hit               | out_valid / out_stall
//
// One transaction at a time. The scan reads one table entry per cycle from
// the key/value memories (single read port); a miss compares all filled
// entries (up to ENTRIES), a hit stops at the matching entry, and the final
// update also waits while the output register stays stalled.
// Reset (rst_n low, synchronous) empties the table at once: the fill count
// marks valid entries, so no clearing pass is needed.
// A result waits in the output register; the next transaction is accepted
// and scanned meanwhile, and only its final update waits for the register.
module fifo_replaced_key_value_cache #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [63:0]        in_key,
  input  logic signed [63:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_value,
  output logic               out_hit
);

  frkvc_pkg::cmd_t    cmd;
  frkvc_pkg::status_t sts;

  // sequencing: idle -> scan (one entry per cycle) -> update/commit
  frkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table memories, fill count, victim pointer, adder, output payload
  frkvc_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_result_value (out_result_value),
    .out_hit          (out_hit)
  );

endmodule
